// ===== design/rpic_pkg.sv =====
// Package for the rate PI controller: register indexes, sequencer states,
// reset values and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package rpic_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET = 3'd0,
    REG_PGAIN  = 3'd1,
    REG_ITIME  = 3'd2,
    REG_FCOEF  = 3'd3,
    REG_WARN   = 3'd4
  } rpic_reg_e;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_PROD,   // target * Ti
    S_CSET,
    S_CDIV,   // c = 2^55 / (target * Ti)
    S_WMUL,   // warn * target
    S_LDIV,   // clamp limit = (target + 2) / 5
    S_RSET,
    S_RDIV,   // raw rate = 65536e6 / period
    S_EMA1,   // a * estimate
    S_EMA2,   // + (1 - a) * raw
    S_ERR,
    S_CLMP,
    S_PI,
    S_SCMUL,  // |s| * c
    S_INNER,
    S_KP,
    S_KPMUL,  // |inner| * Kp
    S_CMD,
    S_OUT
  } rpic_state_e;

  localparam logic [31:0] TargetRst = 32'd65536000;
  localparam logic [23:0] PgainRst  = 24'd65536;
  localparam logic [31:0] ItimeRst  = 32'd65536;
  localparam logic [15:0] FcoefRst  = 16'd62259;
  localparam logic [19:0] WarnRst   = 20'd13107;

  localparam logic [35:0] RateNum   = 36'd65536000000;  // 1e6 in Q16.16
  localparam logic [63:0] CNum      = 64'h0080_0000_0000_0000;  // 2^55
  localparam logic [31:0] Sat32     = 32'hFFFF_FFFF;
  localparam logic [63:0] LimDivisor = 64'd5;
  localparam logic [16:0] OneQ16    = 17'd65536;

  localparam logic [63:0] RoundQ16  = 64'd32768;    // 2^15
  localparam logic [63:0] RoundQ24  = 64'd8388608;  // 2^23

  localparam logic [6:0]  RdivSteps = 7'd36;
  localparam logic [6:0]  CdivSteps = 7'd64;
  localparam logic [6:0]  LdivSteps = 7'd33;

endpackage

// ===== design/rate_pi_controller.sv =====
// Rate PI controller, top level: sequencer with a bit-serial shift-add
// multiplier and a bit-serial restoring divider. Depends on rpic_pkg.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid_i / in_stall_o, now_us_i): one transfer per loop
//   tick, timestamp in microseconds. One tick is worked on at a time; stall
//   is high from the accepting edge until the result is in the output register.
// - Output channel (out_valid_o / out_stall_i): one result transfer per tick:
//   commanded rate, filtered rate estimate, estimate-valid and warning flags.
//   The output register holds a result while the receiver stalls; the next
//   tick may be accepted and worked on meanwhile, and waits in its last
//   state if the register is still full.
// - Config port (cfg_we_i, cfg_addr_i, cfg_data_i): write while idle. A new
//   nonzero target restarts the estimator state. Changes of target, Ti or
//   warn ratio mark derived constants (c, clamp limit, warn product) stale.
// - Work per tick, on the shared multiplier and divider (1 bit/cycle):
//   no measured period: error, clamp and command, then output register;
//   measured period: rate divide (36 quotient bits), then the filter's
//   two multiplies (16- and 17-bit multipliers), then c and Kp (32 and 24
//   bits); the multiplies stop early on short multipliers;
//   first tick after reset or a target, Ti or warn change: rebuilds c (32-bit
//   multiply, 64-bit divide), warn product (20 bits) and clamp limit (33 bits).
// - Reset: documented register values, no tick seen, constants rebuilt.
module rate_pi_controller
  import rpic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_us_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] commanded_rate_o,
  output logic [31:0] estimated_rate_o,
  output logic        estimate_valid_o,
  output logic        rate_warning_o
);

  rpic_state_e state_q, state_d;

  // configuration
  logic [31:0] target_q;
  logic [23:0] pgain_q;
  logic [31:0] itime_q;
  logic [15:0] fcoef_q;
  logic [19:0] warn_q;

  // controller state
  logic [31:0]        last_q;
  logic [31:0]        est_q;
  logic signed [31:0] prev_q;
  logic [31:0]        drive_q;

  // derived constants, rebuilt when dirty
  logic        dirty_q;
  logic [31:0] c_q;
  logic [51:0] wt_q;
  logic [29:0] lim_q;

  // per-tick work registers
  logic               tick_valid_q;
  logic [31:0]        period_q;
  logic [31:0]        raw_q;
  logic signed [32:0] rerr_q;
  logic signed [31:0] err_q;
  logic               warn_flag_q;
  logic signed [32:0] d_q;
  logic               sneg_q;
  logic signed [41:0] inner_q;
  logic               ineg_q;

  // shift-add multiplier
  logic [63:0] acc_q;
  logic [63:0] mcand_q;
  logic [31:0] mplier_q;
  logic [63:0] mul_sum;
  logic        mul_last;
  logic        mul_run;

  // restoring divider: dividend shifts out the top, quotient shifts in below
  logic [63:0] dvd_q;
  logic [63:0] dsr_q;
  logic [63:0] rem_q;
  logic [6:0]  cnt_q;
  logic [64:0] rem_sh;
  logic        div_ge;
  logic [64:0] rem_sub;
  logic [63:0] rem_nx;
  logic [63:0] dvd_nx;
  logic        div_last;
  logic        div_run;

  // output register
  logic        out_valid_q;
  logic [31:0] out_cmd_q;
  logic [31:0] out_est_q;
  logic        out_ev_q;
  logic        out_warn_q;

  logic in_xfer;
  logic out_load;
  logic tick_ok;

  // combinational helpers
  logic signed [32:0] lim_s;
  logic signed [32:0] err_c;
  logic [32:0]        rerr_abs;
  logic               warn_c;
  logic signed [32:0] s_w;
  logic signed [32:0] d_w;
  logic [32:0]        s_abs;
  logic [41:0]        r_mag;
  logic signed [41:0] inner_w;
  logic [41:0]        inner_abs;
  logic [49:0]        delta_mag;
  logic signed [49:0] cmd_w;
  logic [31:0]        cmd_sat;
  logic [16:0]        fcoef_inv;
  logic [35:0]        rate_dvd;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign tick_ok    = (last_q != 32'd0) && (now_us_i > last_q);
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  // datapath arithmetic
  assign mul_sum  = acc_q + (mplier_q[0] ? mcand_q : 64'd0);
  assign mul_last = (mplier_q[31:1] == 31'd0);

  assign rem_sh   = {rem_q, dvd_q[63]};
  assign div_ge   = (rem_sh >= {1'b0, dsr_q});
  assign rem_sub  = rem_sh - {1'b0, dsr_q};
  assign rem_nx   = div_ge ? rem_sub[63:0] : rem_sh[63:0];
  assign dvd_nx   = {dvd_q[62:0], div_ge};
  assign div_last = (cnt_q == 7'd1);

  assign fcoef_inv = OneQ16 - {1'b0, fcoef_q};
  assign rate_dvd  = RateNum + {5'd0, period_q[31:1]};  // rounds half up

  always_comb begin
    // clamp to +/- limit, warning on the unclamped error
    lim_s = $signed({3'b000, lim_q});
    if (rerr_q > lim_s) begin
      err_c = lim_s;
    end else if (rerr_q < -lim_s) begin
      err_c = -lim_s;
    end else begin
      err_c = rerr_q;
    end
    rerr_abs = rerr_q[32] ? 33'(-rerr_q) : 33'(rerr_q);
    warn_c   = ({4'd0, rerr_abs[31:0], 16'd0} > wt_q);

    // trapezoid terms
    d_w   = $signed({err_q[31], err_q}) - $signed({prev_q[31], prev_q});
    s_w   = $signed({err_q[31], err_q}) + $signed({prev_q[31], prev_q});
    s_abs = s_w[32] ? 33'(-s_w) : 33'(s_w);

    // inner = d + sign(s) * round(|s| * c / 2^24)
    r_mag     = {2'd0, acc_q[63:24]};
    inner_w   = $signed({{9{d_q[32]}}, d_q}) +
                (sneg_q ? -$signed(r_mag) : $signed(r_mag));
    inner_abs = inner_q[41] ? 42'(-inner_q) : 42'(inner_q);

    // command = drive + sign(inner) * round(|inner| * Kp / 2^16)
    delta_mag = {2'd0, acc_q[63:16]};
    cmd_w     = $signed({18'd0, drive_q}) +
                (ineg_q ? -$signed(delta_mag) : $signed(delta_mag));
    if (cmd_w[49] || (cmd_w == 50'sd0)) begin
      cmd_sat = 32'd1;
    end else if (cmd_w[49:32] != 18'd0) begin
      cmd_sat = Sat32;
    end else begin
      cmd_sat = cmd_w[31:0];
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and unit enables
  always_comb begin
    state_d = state_q;
    mul_run = 1'b0;
    div_run = 1'b0;
    unique case (state_q) inside
      S_PROD, S_WMUL, S_EMA1, S_EMA2, S_SCMUL, S_KPMUL: mul_run = 1'b1;
      S_CDIV, S_LDIV, S_RDIV:                          div_run = 1'b1;
      default: ;
    endcase

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (dirty_q) begin
            state_d = S_PROD;
          end else if (tick_ok) begin
            state_d = S_RSET;
          end else begin
            state_d = S_ERR;
          end
        end
      end
      S_PROD:  if (mul_last) state_d = S_CSET;
      S_CSET:  state_d = (acc_q == 64'd0) ? S_WMUL : S_CDIV;
      S_CDIV:  if (div_last) state_d = S_WMUL;
      S_WMUL:  if (mul_last) state_d = S_LDIV;
      S_LDIV:  if (div_last) state_d = tick_valid_q ? S_RSET : S_ERR;
      S_RSET:  state_d = S_RDIV;
      S_RDIV:  if (div_last) state_d = S_EMA1;
      S_EMA1:  if (mul_last) state_d = S_EMA2;
      S_EMA2:  if (mul_last) state_d = S_ERR;
      S_ERR:   state_d = S_CLMP;
      S_CLMP:  state_d = tick_valid_q ? S_PI : S_CMD;
      S_PI:    state_d = S_SCMUL;
      S_SCMUL: if (mul_last) state_d = S_INNER;
      S_INNER: state_d = S_KP;
      S_KP:    state_d = S_KPMUL;
      S_KPMUL: if (mul_last) state_d = S_CMD;
      S_CMD:   state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // configuration, controller state and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= TargetRst;
      pgain_q      <= PgainRst;
      itime_q      <= ItimeRst;
      fcoef_q      <= FcoefRst;
      warn_q       <= WarnRst;
      last_q       <= 32'd0;
      est_q        <= TargetRst;
      prev_q       <= 32'sd0;
      drive_q      <= TargetRst;
      dirty_q      <= 1'b1;
      tick_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            tick_valid_q <= tick_ok;
            last_q       <= now_us_i;
          end
        end
        S_LDIV: if (div_last) dirty_q <= 1'b0;
        S_EMA2: if (mul_last) est_q <= mul_sum[47:16];
        S_CMD: begin
          drive_q <= tick_valid_q ? cmd_sat : target_q;
          prev_q  <= err_q;
        end
        default: ;
      endcase

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_TARGET: begin
            if ((cfg_data_i != 32'd0) && (cfg_data_i != target_q)) begin
              target_q <= cfg_data_i;
              est_q    <= cfg_data_i;
              prev_q   <= 32'sd0;
              last_q   <= 32'd0;
              dirty_q  <= 1'b1;
            end
          end
          REG_PGAIN: pgain_q <= cfg_data_i[23:0];
          REG_ITIME: begin
            itime_q <= cfg_data_i;
            dirty_q <= 1'b1;
          end
          REG_FCOEF: fcoef_q <= cfg_data_i[15:0];
          REG_WARN: begin
            warn_q  <= cfg_data_i[19:0];
            dirty_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // arithmetic units and work registers
  always_ff @(posedge clk_i) begin
    if (mul_run) begin
      acc_q <= mul_sum;
      if ((state_q == S_EMA1) && mul_last) begin
        // second filter product: (1 - a) * raw
        mcand_q  <= {32'd0, raw_q};
        mplier_q <= {15'd0, fcoef_inv};
      end else begin
        mcand_q  <= {mcand_q[62:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[31:1]};
      end
    end
    if (div_run) begin
      rem_q <= rem_nx;
      dvd_q <= dvd_nx;
      cnt_q <= cnt_q - 7'd1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          period_q <= now_us_i - last_q;
          acc_q    <= 64'd0;
          mcand_q  <= {32'd0, target_q};
          mplier_q <= itime_q;
        end
      end
      S_CSET: begin
        if (acc_q == 64'd0) begin
          // zero integral time: c saturates
          c_q      <= Sat32;
          acc_q    <= 64'd0;
          mcand_q  <= {32'd0, target_q};
          mplier_q <= {12'd0, warn_q};
        end else begin
          dvd_q <= CNum + {1'b0, acc_q[63:1]};
          dsr_q <= acc_q;
          rem_q <= 64'd0;
          cnt_q <= CdivSteps;
        end
      end
      S_CDIV: begin
        if (div_last) begin
          c_q      <= (dvd_nx[63:32] != 32'd0) ? Sat32 : dvd_nx[31:0];
          acc_q    <= 64'd0;
          mcand_q  <= {32'd0, target_q};
          mplier_q <= {12'd0, warn_q};
        end
      end
      S_WMUL: begin
        if (mul_last) begin
          wt_q  <= mul_sum[51:0];
          dvd_q <= {33'(target_q) + 33'd2, 31'd0};
          dsr_q <= LimDivisor;
          rem_q <= 64'd0;
          cnt_q <= LdivSteps;
        end
      end
      S_LDIV: if (div_last) lim_q <= dvd_nx[29:0];
      S_RSET: begin
        dvd_q <= {rate_dvd, 28'd0};
        dsr_q <= {32'd0, period_q};
        rem_q <= 64'd0;
        cnt_q <= RdivSteps;
      end
      S_RDIV: begin
        if (div_last) begin
          raw_q    <= (dvd_nx[35:32] != 4'd0) ? Sat32 : dvd_nx[31:0];
          acc_q    <= RoundQ16;
          mcand_q  <= {32'd0, est_q};
          mplier_q <= {16'd0, fcoef_q};
        end
      end
      S_ERR: rerr_q <= $signed({1'b0, target_q}) - $signed({1'b0, est_q});
      S_CLMP: begin
        err_q       <= err_c[31:0];
        warn_flag_q <= warn_c;
      end
      S_PI: begin
        d_q      <= d_w;
        sneg_q   <= s_w[32];
        acc_q    <= RoundQ24;
        mcand_q  <= {32'd0, s_abs[31:0]};
        mplier_q <= c_q;
      end
      S_INNER: inner_q <= inner_w;
      S_KP: begin
        ineg_q   <= inner_q[41];
        acc_q    <= RoundQ16;
        mcand_q  <= {22'd0, inner_abs};
        mplier_q <= {8'd0, pgain_q};
      end
      default: ;
    endcase

    if (out_load) begin
      out_cmd_q  <= drive_q;
      out_est_q  <= est_q;
      out_ev_q   <= tick_valid_q;
      out_warn_q <= warn_flag_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign commanded_rate_o = out_cmd_q;
  assign estimated_rate_o = out_est_q;
  assign estimate_valid_o = out_ev_q;
  assign rate_warning_o   = out_warn_q;

endmodule

// ===== tb/rate_pi_checker.sv =====
// Rate PI controller checker: watches config writes and both channels, predicts
// each tick result and compares it field by field. Depends on rpic_pkg.
`timescale 1ns / 1ps

module rate_pi_checker
  import rpic_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] now_us_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] commanded_rate_i,
  input  logic [31:0] estimated_rate_i,
  input  logic        estimate_valid_i,
  input  logic        rate_warning_i,
  output int          fail_count_o,
  output int          outstanding_o
);

  typedef struct packed {
    logic [31:0] commanded_rate;
    logic [31:0] estimated_rate;
    logic        estimate_valid;
    logic        rate_warning;
  } tick_result_t;

  localparam logic [63:0] Mask32    = 64'hFFFF_FFFF;
  localparam logic [63:0] UsPerSecQ = 64'd65536000000;  // 1e6 in Q16.16

  // loop settings
  logic [31:0] tgt_rate;
  logic [23:0] kp_gain;
  logic [31:0] ti_time;
  logic [15:0] lp_coef;
  logic [19:0] warn_lim;

  // loop state
  logic [31:0] prior_tick;
  logic [31:0] est_rate;
  longint      err_prev;
  logic [31:0] cmd_rate;

  tick_result_t pending_ticks[$];
  int           mismatches;

  // sign(a) * round(|a| * b / 2^sh), half away from zero
  function automatic longint scaled_round(longint a, logic [63:0] b, int unsigned sh);
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] r;
    mag  = (a < 0) ? 64'(-a) : 64'(a);
    prod = mag * b;
    r    = (prod + (64'd1 << (sh - 1))) >> sh;
    return (a < 0) ? -$signed(r) : $signed(r);
  endfunction

  function automatic void apply_write(logic [2:0] addr, logic [31:0] data);
    case (addr)
      REG_TARGET: begin
        // zero or unchanged target leaves the loop alone
        if (data != 32'd0 && data != tgt_rate) begin
          tgt_rate   = data;
          err_prev   = 0;
          est_rate   = data;
          prior_tick = 32'd0;
        end
      end
      REG_PGAIN: kp_gain  = data[23:0];
      REG_ITIME: ti_time  = data;
      REG_FCOEF: lp_coef  = data[15:0];
      REG_WARN:  warn_lim = data[19:0];
      default: ;
    endcase
  endfunction

  function automatic tick_result_t advance_tick(logic [31:0] now);
    tick_result_t res;
    logic [63:0]  period;
    logic [63:0]  raw;
    logic [63:0]  acc;
    logic [63:0]  prod;
    logic [63:0]  c;
    logic [63:0]  abs_err;
    longint       err_raw;
    longint       lim;
    longint       err;
    longint       d;
    longint       s;
    longint       inner;
    longint       delta;
    longint       cmd;
    logic         measured;
    measured = 1'b0;
    if (prior_tick != 32'd0 && now > prior_tick) begin
      period = {32'd0, now - prior_tick};
      raw    = (UsPerSecQ + period / 2) / period;
      if (raw > Mask32) raw = Mask32;
      acc      = 64'(lp_coef) * 64'(est_rate) + (64'd65536 - 64'(lp_coef)) * raw;
      est_rate = 32'((acc + 64'd32768) >> 16);
      measured = 1'b1;
    end
    prior_tick = now;

    err_raw = $signed({32'd0, tgt_rate}) - $signed({32'd0, est_rate});
    lim     = $signed((64'(tgt_rate) + 64'd2) / 64'd5);
    err     = err_raw;
    if (err > lim) err = lim;
    if (err < -lim) err = -lim;
    abs_err = (err_raw < 0) ? 64'(-err_raw) : 64'(err_raw);

    if (measured) begin
      // trapezoidal PI step, c = 1 / (2 * target * Ti) in Q8.24
      d    = err - err_prev;
      s    = err + err_prev;
      prod = 64'(tgt_rate) * 64'(ti_time);
      if (prod == 64'd0) begin
        c = Mask32;
      end else begin
        c = ((64'd1 << 55) + prod / 2) / prod;
        if (c > Mask32) c = Mask32;
      end
      inner = d + scaled_round(s, c, 24);
      delta = scaled_round(inner, 64'(kp_gain), 16);
      cmd   = $signed({32'd0, cmd_rate}) + delta;
    end else begin
      cmd = $signed({32'd0, tgt_rate});
    end
    if (cmd < 1) cmd = 1;
    if (cmd > $signed(Mask32)) cmd = $signed(Mask32);
    cmd_rate = cmd[31:0];
    err_prev = err;

    res.commanded_rate = cmd_rate;
    res.estimated_rate = est_rate;
    res.estimate_valid = measured;
    res.rate_warning   = (abs_err << 16) > (64'(warn_lim) * 64'(tgt_rate));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want;
    if (!rst_ni) begin
      tgt_rate      = TargetRst;
      kp_gain       = PgainRst;
      ti_time       = ItimeRst;
      lp_coef       = FcoefRst;
      warn_lim      = WarnRst;
      prior_tick    = 32'd0;
      est_rate      = TargetRst;
      err_prev      = 0;
      cmd_rate      = TargetRst;
      mismatches    = 0;
      pending_ticks.delete();
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) apply_write(cfg_addr_i, cfg_data_i);

      if (out_valid_i && !out_stall_i) begin
        if (pending_ticks.size() == 0) begin
          $error("result transfer with no tick outstanding");
          mismatches++;
        end else begin
          want = pending_ticks.pop_front();
          if (commanded_rate_i !== want.commanded_rate) begin
            $error("commanded_rate: expected %0d, got %0d", want.commanded_rate,
                   commanded_rate_i);
            mismatches++;
          end
          if (estimated_rate_i !== want.estimated_rate) begin
            $error("estimated_rate: expected %0d, got %0d", want.estimated_rate,
                   estimated_rate_i);
            mismatches++;
          end
          if (estimate_valid_i !== want.estimate_valid) begin
            $error("estimate_valid: expected %0d, got %0d", want.estimate_valid,
                   estimate_valid_i);
            mismatches++;
          end
          if (rate_warning_i !== want.rate_warning) begin
            $error("rate_warning: expected %0d, got %0d", want.rate_warning,
                   rate_warning_i);
            mismatches++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) pending_ticks.push_back(advance_tick(now_us_i));

      fail_count_o  <= mismatches;
      outstanding_o <= pending_ticks.size();
    end
  end

endmodule

// ===== tb/rate_pi_controller_tb.sv =====
// Rate PI controller testbench top: clock, reset, tick and config stimulus,
// verdict. Depends on rpic_pkg, rate_pi_controller and rate_pi_checker.
`timescale 1ns / 1ps

module rate_pi_controller_tb;
  import rpic_pkg::*;

  // Guard against a hung handshake. A correct run needs roughly
  // 1900 ticks, each with its busy time plus gaps/stalls; the limit is several times that.
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned PhaseTicks = 230;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned QuietPhase = 5;
  localparam int unsigned IdlePct    = 22;
  // first of the unused register indexes; writes there must be ignored
  localparam logic [2:0]  RegSpare   = 3'd5;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] now_us_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] commanded_rate_o;
  logic [31:0] estimated_rate_o;
  logic        estimate_valid_o;
  logic        rate_warning_o;

  int          fail_count;
  int          outstanding;
  int unsigned cycle_count = 0;
  bit          quiet;  // no sender gaps and no receiver stalls while set

  rate_pi_controller DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .now_us_i         (now_us_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .commanded_rate_o (commanded_rate_o),
    .estimated_rate_o (estimated_rate_o),
    .estimate_valid_o (estimate_valid_o),
    .rate_warning_o   (rate_warning_o)
  );

  rate_pi_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .now_us_i         (now_us_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .commanded_rate_i (commanded_rate_o),
    .estimated_rate_i (estimated_rate_o),
    .estimate_valid_i (estimate_valid_o),
    .rate_warning_i   (rate_warning_o),
    .fail_count_o     (fail_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls, changed on the falling edge only.
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < IdlePct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("rate_pi_controller test failed");
      $finish;
    end
  end

  // One tick transfer. Entered and left on a falling edge. Within this task valid
  // is only dropped inside a gap, so it is never lowered and raised in one step.
  task automatic send_tick(input logic [31:0] stamp_us);
    while (!quiet && $urandom_range(0, 99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_us_i   <= stamp_us;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Stop sending and let every outstanding tick come back; the block is
  // idle afterwards, which is when register writes are allowed.
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (outstanding == 0);
    repeat (8) @(negedge clk_i);
  endtask

  // Leaves the write enable high; end_writes drops it.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(negedge clk_i);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Full register set; upper data bits above each register's width are junk
  // so the width masking gets exercised.
  task automatic program_loop(input logic [31:0] tgt, input logic [23:0] kp,
                              input logic [31:0] ti, input logic [15:0] fc,
                              input logic [19:0] warn);
    write_reg(REG_TARGET, tgt);
    write_reg(REG_PGAIN, {8'($urandom), kp});
    write_reg(REG_ITIME, ti);
    write_reg(REG_FCOEF, {16'($urandom), fc});
    write_reg(REG_WARN, {12'($urandom), warn});
    write_reg(3'(RegSpare + $urandom_range(0, 2)), $urandom);
    end_writes();
  endtask

  initial begin
    logic [31:0] tgt;
    logic [31:0] ti;
    logic [23:0] kp;
    logic [15:0] fc;
    logic [19:0] warn;
    logic [31:0] stamp;
    logic [63:0] nominal;
    int unsigned pick;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = REG_TARGET;
    cfg_data_i  = 32'd0;
    in_valid_i  = 1'b0;
    now_us_i    = 32'd0;
    out_stall_i = 1'b0;
    quiet       = 1'b0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // --- directed: reset settings (1000 Hz target) ---
    send_tick(32'd0);           // zero timestamp: no tick seen afterward
    send_tick(32'd0);
    send_tick(32'd1000);        // first real tick, no period yet
    send_tick(32'd2000);        // nominal 1 ms period
    send_tick(32'd2000);        // time not advanced
    send_tick(32'd1500);        // time went backward
    send_tick(32'd2500);
    send_tick(32'd2501);        // 1 us period, raw rate saturates
    send_tick(32'hFFFF_FFFF);   // very long period, tiny raw rate
    send_tick(32'd0);           // zero again restarts the first-tick case
    send_tick(32'd5);
    send_tick(32'd1005);

    // Zero target and rewrite of the current target must not touch the
    // estimator: the next tick still measures a period from the last one.
    drain();
    write_reg(REG_TARGET, 32'd0);
    write_reg(REG_TARGET, TargetRst);
    end_writes();
    send_tick(32'd2005);

    // New target restarts the loop; zero Ti saturates c; max Kp, no filtering.
    drain();
    program_loop(32'd131072000, 24'hFF_FFFF, 32'd0, 16'd0, 20'd0);
    send_tick(32'd3005);
    send_tick(32'd3505);
    send_tick(32'd4005);

    // Smallest target, zero Kp, heaviest filter, widest warn ratio.
    drain();
    program_loop(32'd1, 24'd0, 32'd1, 16'hFFFF, 20'hF_FFFF);
    send_tick(32'd7);
    send_tick(32'd8);
    send_tick(32'd1_000_008);

    // Largest target and Ti.
    drain();
    program_loop(32'hFFFF_FFFF, 24'd65536, 32'hFFFF_FFFF, 16'd32768, 20'd13107);
    send_tick(32'd10);
    send_tick(32'd11);
    send_tick(32'd12);

    // --- random phases, each with its own loop settings ---
    for (int unsigned p = 0; p < NumPhases; p++) begin
      tgt  = ($urandom_range(50, 20000) << 16) | $urandom_range(0, 65535);
      kp   = 24'($urandom_range(0, 4 * 65536));
      ti   = $urandom_range(6554, 10 * 65536);
      fc   = 16'($urandom_range(0, 65535));
      warn = 20'($urandom_range(0, 65536));
      case (p)
        1: begin
          kp = 24'hFF_FFFF;
          fc = 16'hFFFF;
        end
        2: begin
          kp   = 24'd0;
          fc   = 16'd0;
          warn = 20'd0;
        end
        3: begin
          tgt  = 32'hFFFF_FFFF;
          ti   = 32'hFFFF_FFFF;
          warn = 20'hF_FFFF;
        end
        4: begin
          tgt = 32'd1;
          ti  = 32'd1;
        end
        default: ;
      endcase

      drain();
      program_loop(tgt, kp, ti, fc, warn);
      quiet = (p == QuietPhase);

      // tick period that matches the target, kept in a sane range
      nominal = 64'd65536000000 / 64'(tgt);
      if (nominal > 64'h100_0000) nominal = 64'h100_0000;
      if (nominal == 64'd0) nominal = 64'd1;
      stamp = $urandom;

      // Mostly jittered ticks around the target period so the loop actually
      // settles and tracks; the rest are stalls in time, backward steps,
      // zero stamps, random jumps and near-zero periods.
      for (int unsigned i = 0; i < PhaseTicks; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)      stamp = stamp + 32'(nominal * $urandom_range(70, 130) / 100) + 1;
        else if (pick < 85) stamp = stamp;
        else if (pick < 90) stamp = stamp - $urandom_range(1, 5000);
        else if (pick < 93) stamp = 32'd0;
        else if (pick < 97) stamp = $urandom;
        else                stamp = stamp + $urandom_range(1, 3);
        send_tick(stamp);
      end
      quiet = 1'b0;
    end

    drain();
    repeat (300) @(negedge clk_i);
    if (fail_count == 0) $display("rate_pi_controller test passed");
    else $display("rate_pi_controller test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rpic_pkg.sv
design/rate_pi_controller.sv
tb/rate_pi_checker.sv
tb/rate_pi_controller_tb.sv
